[rtl/gbba_pkg.sv]
`timescale 1ns / 1ps
package gbba_pkg;

    // Default sizing of the store
    localparam int DEF_MAX_GROUPS           = 8;
    localparam int DEF_MAX_BLOCKS_PER_GROUP = 4096;

    // Field widths
    localparam int BLOCK_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int GCNT_W   = 13;
    localparam int WORD_W   = 64;

    // Count limits
    localparam logic [GCNT_W-1:0]  GROUP_COUNT_MAX = 13'h1FFF;
    localparam logic [BLOCK_W-1:0] TOTAL_COUNT_MAX = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd2;

    // Action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

    // Result of the shared subtract/compare unit
    typedef struct packed {
        logic [BLOCK_W-1:0] diff;
        logic               borrow;
    } alu_res_t;

endpackage

[rtl/gbba_in_if.sv]
`timescale 1ns / 1ps
interface gbba_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] block_number;

    modport source (output valid, output action, output block_number, input ready);
    modport sink   (input valid, input action, input block_number, output ready);
endinterface

[rtl/gbba_out_if.sv]
`timescale 1ns / 1ps
interface gbba_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] allocated_block;
    logic [1:0]  status;
    logic [15:0] free_total;

    modport source (output valid, output allocated_block, output status,
                    output free_total, input ready);
    modport sink   (input valid, input allocated_block, input status,
                    input free_total, output ready);
endinterface

[rtl/gbba_ram.sv]
`timescale 1ns / 1ps
module gbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gbba_alu.sv]
`timescale 1ns / 1ps
module gbba_alu (
    input  logic [15:0]       a,
    input  logic [15:0]       b,
    output gbba_pkg::alu_res_t res
);
    import gbba_pkg::*;

    logic [BLOCK_W:0] full;

    // Subtract with borrow out; borrow means a < b
    assign full       = {1'b0, a} - {1'b0, b};
    assign res.diff   = full[BLOCK_W-1:0];
    assign res.borrow = full[BLOCK_W];

endmodule

[rtl/grouped_bitmap_block_allocator.sv]
`timescale 1ns / 1ps
// Grouped first-fit bitmap block allocator. An allocate scans the groups in
// order, skips groups whose free count is zero, and reads the group's bitmap
// one 64-bit word at a time, each word with a memory read, then a test. A
// free divides the relative block number by repeated subtraction in one
// shared subtract unit, one group per cycle, then reads the word and clears
// the block's bit if it is set. One item is in work at a time; a finished
// result waits in the output register while the next item is taken. After
// reset a clearing pass writes all MAX_GROUPS * ceil(MAX_BLOCKS_PER_GROUP / 64)
// words (512 with the defaults) and marks every block used; no item is
// accepted during it. All counts start at zero, so software fills the store by
// freeing blocks.
module grouped_bitmap_block_allocator #(
    parameter int MAX_GROUPS           = gbba_pkg::DEF_MAX_GROUPS,
    parameter int MAX_BLOCKS_PER_GROUP = gbba_pkg::DEF_MAX_BLOCKS_PER_GROUP
) (
    input  logic                             clk,
    input  logic                             rst_n,
    gbba_in_if.sink                          in_ch,
    gbba_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gbba_pkg::*;

    localparam int WPG    = (MAX_BLOCKS_PER_GROUP + WORD_W - 1) / WORD_W;
    localparam int DEPTH  = MAX_GROUPS * WPG;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WI_W   = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int GI_W   = $clog2(MAX_GROUPS + 1);
    localparam int GX_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam logic [ADDR_W-1:0]  WPG_A    = ADDR_W'(WPG);
    localparam logic [ADDR_W-1:0]  LAST_A   = ADDR_W'(DEPTH - 1);
    localparam logic [7:0]         MAXG_8   = 8'(MAX_GROUPS);
    localparam logic [BLOCK_W-1:0] MAXB_16  = BLOCK_W'(MAX_BLOCKS_PER_GROUP);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_A_GRP, ST_A_REQ, ST_A_CHK,
        ST_F_SUB, ST_F_DIV, ST_F_REQ, ST_F_CHK, ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [3:0]  gc_reg;
    logic [12:0] bpg_reg;
    logic [7:0]  fdb_reg;

    // Working registers
    logic [GI_W-1:0]    g_reg;
    logic [WI_W-1:0]    wi_reg;
    logic [5:0]         bit_reg;
    logic [ADDR_W-1:0]  gaddr_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [BLOCK_W-1:0] base_reg;
    logic [BLOCK_W-1:0] rel_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [BLOCK_W-1:0] res_reg;
    logic [STATUS_W-1:0] stat_reg;
    logic [GCNT_W-1:0]  cnt_reg [MAX_GROUPS];
    logic [BLOCK_W-1:0] total_reg;

    // Output register
    logic                out_valid_reg;
    logic [BLOCK_W-1:0]  out_block_reg;
    logic [STATUS_W-1:0] out_stat_reg;
    logic [BLOCK_W-1:0]  out_total_reg;

    // Effective limits
    logic [GI_W-1:0]    gc_eff;
    logic [BLOCK_W-1:0] bpg_eff;
    logic [7:0]         gc_8;
    logic [BLOCK_W-1:0] bpg_16;

    assign gc_8    = {4'b0, gc_reg};
    assign bpg_16  = {3'b0, bpg_reg};
    assign gc_eff  = (gc_8 > MAXG_8) ? GI_W'(MAX_GROUPS) : GI_W'(gc_8);
    assign bpg_eff = (bpg_16 > MAXB_16) ? MAXB_16 : bpg_16;

    // Memory signals
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] cur_addr;
    logic [WORD_W-1:0] ram_rdata;

    assign cur_addr = gaddr_reg + ADDR_W'(wi_reg);

    gbba_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    // Shared subtract unit: base removal and division steps
    logic [BLOCK_W-1:0] alu_a;
    logic [BLOCK_W-1:0] alu_b;
    alu_res_t           alu_res;

    assign alu_a = (state_reg == ST_F_SUB) ? blk_reg : rel_reg;
    assign alu_b = (state_reg == ST_F_SUB) ? {8'b0, fdb_reg} : bpg_eff;

    gbba_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Find the lowest clear bit of a word
    function automatic logic [5:0] ffz(input logic [WORD_W-1:0] w);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    // Bit test of the current word against the group's range
    logic [BLOCK_W-1:0] word_off;
    logic [BLOCK_W-1:0] rem;
    logic [WORD_W-1:0]  vmask;
    logic [WORD_W-1:0]  masked;
    logic               word_full;
    logic [5:0]         zero_idx;
    logic [BLOCK_W-1:0] last_word_16;
    logic [WI_W-1:0]    last_word;
    logic [GX_W-1:0]    gx;

    assign word_off     = BLOCK_W'({wi_reg, 6'b0});
    assign rem          = bpg_eff - word_off;
    assign vmask        = (rem >= BLOCK_W'(WORD_W)) ? '1
                          : ((WORD_W'(1) << rem[5:0]) - WORD_W'(1));
    assign masked       = ram_rdata | ~vmask;
    assign word_full    = &masked;
    assign zero_idx     = ffz(masked);
    assign last_word_16 = (bpg_eff - BLOCK_W'(1)) >> 6;
    assign last_word    = WI_W'(last_word_16);
    assign gx           = g_reg[GX_W-1:0];

    // Memory writes: clearing pass, allocate set, free clear
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
            end
            ST_A_CHK:
            begin
                ram_we    = !word_full;
                ram_wdata = ram_rdata | (WORD_W'(1) << zero_idx);
            end
            ST_F_CHK:
            begin
                ram_we    = ram_rdata[bit_reg];
                ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    logic out_load;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.allocated_block = out_block_reg;
    assign out_ch.status          = out_stat_reg;
    assign out_ch.free_total      = out_total_reg;

    // Sequencer, counts and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            gc_reg        <= 4'd8;
            bpg_reg       <= 13'd4096;
            fdb_reg       <= 8'd0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            g_reg         <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_GROUP_COUNT:      gc_reg  <= cfg_data[3:0];
                    CFG_BLOCKS_PER_GROUP: bpg_reg <= cfg_data;
                    CFG_FIRST_DATA_BLOCK: fdb_reg <= cfg_data[7:0];
                    default:              ;
                endcase
            end

            // Drop the output after its transfer, reload when finished
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_block_reg <= res_reg;
                out_stat_reg  <= stat_reg;
                out_total_reg <= total_reg;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == LAST_A)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    g_reg     <= '0;
                    wi_reg    <= '0;
                    gaddr_reg <= '0;
                    base_reg  <= '0;
                    res_reg   <= '0;
                    stat_reg  <= STAT_OK;
                    blk_reg   <= in_ch.block_number;
                    if (in_ch.valid)
                    begin
                        state_reg <= (in_ch.action == ACT_FREE) ? ST_F_SUB : ST_A_GRP;
                    end
                end
                ST_A_GRP:
                begin
                    wi_reg <= '0;
                    if (g_reg >= gc_eff || bpg_eff == '0)
                    begin
                        stat_reg  <= STAT_NO_SPACE;
                        state_reg <= ST_FIN;
                    end
                    else if (cnt_reg[gx] == '0)
                    begin
                        g_reg     <= g_reg + GI_W'(1);
                        base_reg  <= base_reg + bpg_eff;
                        gaddr_reg <= gaddr_reg + WPG_A;
                    end
                    else
                    begin
                        state_reg <= ST_A_REQ;
                    end
                end
                ST_A_REQ:
                begin
                    state_reg <= ST_A_CHK;
                end
                ST_A_CHK:
                begin
                    if (!word_full)
                    begin
                        res_reg     <= base_reg + word_off + BLOCK_W'(zero_idx)
                                       + {8'b0, fdb_reg};
                        cnt_reg[gx] <= cnt_reg[gx] - GCNT_W'(1);
                        if (total_reg != '0)
                        begin
                            total_reg <= total_reg - BLOCK_W'(1);
                        end
                        state_reg <= ST_FIN;
                    end
                    else if (wi_reg == last_word)
                    begin
                        g_reg     <= g_reg + GI_W'(1);
                        base_reg  <= base_reg + bpg_eff;
                        gaddr_reg <= gaddr_reg + WPG_A;
                        state_reg <= ST_A_GRP;
                    end
                    else
                    begin
                        wi_reg    <= wi_reg + WI_W'(1);
                        state_reg <= ST_A_REQ;
                    end
                end
                ST_F_SUB:
                begin
                    rel_reg <= alu_res.diff;
                    if (alu_res.borrow || bpg_eff == '0)
                    begin
                        stat_reg  <= STAT_RANGE;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_F_DIV;
                    end
                end
                ST_F_DIV:
                begin
                    if (g_reg >= gc_eff)
                    begin
                        stat_reg  <= STAT_RANGE;
                        state_reg <= ST_FIN;
                    end
                    else if (alu_res.borrow)
                    begin
                        wi_reg    <= WI_W'(rel_reg >> 6);
                        bit_reg   <= rel_reg[5:0];
                        state_reg <= ST_F_REQ;
                    end
                    else
                    begin
                        rel_reg   <= alu_res.diff;
                        g_reg     <= g_reg + GI_W'(1);
                        gaddr_reg <= gaddr_reg + WPG_A;
                    end
                end
                ST_F_REQ:
                begin
                    state_reg <= ST_F_CHK;
                end
                ST_F_CHK:
                begin
                    if (ram_rdata[bit_reg])
                    begin
                        if (cnt_reg[gx] != GROUP_COUNT_MAX)
                        begin
                            cnt_reg[gx] <= cnt_reg[gx] + GCNT_W'(1);
                        end
                        if (total_reg != TOTAL_COUNT_MAX)
                        begin
                            total_reg <= total_reg + BLOCK_W'(1);
                        end
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A pending result is never overwritten while the sink stalls
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !out_ch.ready) |=> state_reg == ST_FIN)
        else $error("finished result advanced over a stalled output");

    // Memory writes happen only in the clearing pass or a test cycle
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_A_CHK
                    || state_reg == ST_F_CHK))
        else $error("bitmap write outside a write state");

    // A bitmap test uses a group inside the configured range
    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_CHK || state_reg == ST_F_CHK) |-> g_reg < gc_eff)
        else $error("bitmap access beyond the last group");

    // An allocate only picks a group whose count was nonzero
    a_alloc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_CHK && !word_full) |-> cnt_reg[gx] != '0)
        else $error("allocate from a group with zero free count");

endmodule
